// ===== hdl/eye_chroma_map_pixel_macros.svh =====
// ----------------------------------------------------------------------------
// eye_chroma_map_pixel_macros
// assertion macros used by the checker file of the eye-map block
// ----------------------------------------------------------------------------
`ifndef EYE_CHROMA_MAP_PIXEL_MACROS_SVH
`define EYE_CHROMA_MAP_PIXEL_MACROS_SVH

// concurrent check that is switched off while reset is asserted
`define ECM_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("eye map check failed");

// concurrent check that also holds while reset is asserted
`define ECM_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("eye map reset check failed");

`endif

// ===== hdl/ecm_pkg.sv =====
// ----------------------------------------------------------------------------
// ecm_pkg
// types, constants and helper functions of the chroma eye-map pipeline
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ecm_pkg;

  // field widths
  localparam int unsigned ByteW  = 8;
  localparam int unsigned NumW   = ByteW + 9;   // cb * 512
  localparam int unsigned ProdW  = 2 * ByteW;   // byte squared
  localparam int unsigned TsumW  = ByteW + 1;   // sum of the two square terms
  localparam int unsigned SumW   = ByteW + 2;   // sum of all three terms

  // full-scale byte value
  localparam logic [ByteW-1:0] FullScale = 8'd255;

  // floor(s / 3) as (s * 683) >> 11, exact for s up to 2047 / 3 * 3
  localparam logic [SumW-1:0] Div3Mul   = 10'd683;
  localparam int unsigned     Div3Shift = 11;

  // word handed from one divider cell to the next
  typedef struct packed {
    logic             valid;
    logic [NumW-1:0]  rem;    // partial remainder
    logic [ByteW-1:0] dvs;    // divisor, the cr byte
    logic [ByteW-1:0] quo;    // quotient bits found so far
    logic             sat;    // ratio term saturates at full scale
    logic [TsumW-1:0] tsum;   // both square terms already added
  } link_t;

  // floor(x / 255) for x up to 255 * 255, one estimate and one correction
  function automatic logic [ByteW-1:0] over_full(input logic [ProdW-1:0] x);
    logic [ProdW:0]   est_sum;
    logic [ByteW:0]   q0;
    logic [ProdW+1:0] back;
    logic [ProdW+1:0] r;
    logic [ByteW:0]   q1;
    est_sum = {1'b0, x} + {9'd0, x[ProdW-1:ByteW]};
    q0      = {1'b0, est_sum[ProdW-1:ByteW]};
    back    = {q0, 9'd0} - {9'd0, q0} - {q0, 9'd0} + ({q0, 9'd0} >> 1);
    r       = {2'b00, x} - back;
    q1      = (r >= 18'd255) ? q0 + 9'd1 : q0;
    return q1[ByteW-1:0];
  endfunction

endpackage

// ===== hdl/ecm_div_cell.sv =====
// ----------------------------------------------------------------------------
// ecm_div_cell
// one restoring division cell: finds a single quotient bit and passes on
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ecm_div_cell #(
  parameter int unsigned BIT = 0
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  ecm_pkg::link_t link_i,
  output ecm_pkg::link_t link_o
);

  logic [ecm_pkg::NumW-1:0] shifted;
  logic [ecm_pkg::NumW:0]   diff;
  logic                     take;
  ecm_pkg::link_t           nxt_d;
  logic                     valid_q;
  ecm_pkg::link_t           pay_q;

  // trial subtract of the divisor at this bit weight
  always_comb begin
    shifted = {{(ecm_pkg::NumW - ecm_pkg::ByteW){1'b0}}, link_i.dvs} << BIT;
    diff    = {1'b0, link_i.rem} - {1'b0, shifted};
    take    = !diff[ecm_pkg::NumW];
    nxt_d   = link_i;
    if (take) begin
      nxt_d.rem      = diff[ecm_pkg::NumW-1:0];
      nxt_d.quo[BIT] = 1'b1;
    end
  end

  // valid bit of this cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= link_i.valid;
    end
  end

  // payload of this cell
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pay_q <= nxt_d;
    end
  end

  always_comb begin
    link_o       = pay_q;
    link_o.valid = valid_q;
  end

endmodule

// ===== hdl/eye_chroma_map_pixel.sv =====
// ----------------------------------------------------------------------------
// eye_chroma_map_pixel
// chroma eye-map value of one pixel from its cr and cb bytes
// ----------------------------------------------------------------------------
// Takes one pixel per clock when not stalled and passes it through
// one product stage, eight divider cells and one output stage. The ratio
// term cb * 512 / cr is worked out by a row of eight restoring division
// cells, one quotient bit per cell, and that row sets the latency; the two
// squared terms ride along in the same words. A stall on the output freezes
// the whole pipe, so in_stall_o follows out_stall_i while a word waits.
`timescale 1ns / 1ps

module eye_chroma_map_pixel (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] cr_byte_i,
  input  logic [7:0] cb_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] eye_map_value_o
);

  localparam int unsigned Cells = ecm_pkg::ByteW;

  logic                            en;
  logic                            v1_q;
  logic [ecm_pkg::ProdW-1:0]       pcb_q;
  logic [ecm_pkg::ProdW-1:0]       pcr_q;
  logic [ecm_pkg::NumW-1:0]        num_q;
  logic [ecm_pkg::ByteW-1:0]       cr_q;
  logic                            sat_q;
  logic [ecm_pkg::ByteW-1:0]       inv_cr;
  ecm_pkg::link_t                  chain [Cells+1];
  logic [ecm_pkg::ByteW-1:0]       ratio;
  logic [ecm_pkg::SumW-1:0]        sum;
  logic [2*ecm_pkg::SumW-1:0]      prod3;
  logic                            out_valid_q;
  logic [ecm_pkg::ByteW-1:0]       value_q;

  // the pipe moves unless a finished word is held at the output
  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;
  assign inv_cr     = ~cr_byte_i;

  // product stage: squares, dividend and saturation test
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (en) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pcb_q <= {8'd0, cb_byte_i} * {8'd0, cb_byte_i};
      pcr_q <= {8'd0, inv_cr} * {8'd0, inv_cr};
      num_q <= {cb_byte_i, 9'd0};
      cr_q  <= cr_byte_i;
      // quotient above full scale, also covers zero red
      sat_q <= ({cb_byte_i, 1'b0} >= {1'b0, cr_byte_i});
    end
  end

  // word entering the divider row
  always_comb begin
    chain[0].valid = v1_q;
    chain[0].rem   = num_q;
    chain[0].dvs   = cr_q;
    chain[0].quo   = '0;
    chain[0].sat   = sat_q;
    chain[0].tsum  = {1'b0, ecm_pkg::over_full(pcb_q)}
                   + {1'b0, ecm_pkg::over_full(pcr_q)};
  end

  // row of division cells, most significant quotient bit first
  for (genvar i = 0; i < Cells; i++) begin : g_cell
    ecm_div_cell #(
      .BIT(Cells - 1 - i)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .en_i  (en),
      .link_i(chain[i]),
      .link_o(chain[i+1])
    );
  end

  // output stage: add the three terms and divide by three
  always_comb begin
    ratio = chain[Cells].sat ? ecm_pkg::FullScale : chain[Cells].quo;
    sum   = {1'b0, chain[Cells].tsum} + {2'b00, ratio};
    prod3 = {{ecm_pkg::SumW{1'b0}}, sum} * {{ecm_pkg::SumW{1'b0}}, ecm_pkg::Div3Mul};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= chain[Cells].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      value_q <= prod3[ecm_pkg::Div3Shift +: ecm_pkg::ByteW];
    end
  end

  assign out_valid_o     = out_valid_q;
  assign eye_map_value_o = value_q;

endmodule

// ===== hdl/eye_chroma_map_pixel_chk.sv =====
// ----------------------------------------------------------------------------
// eye_chroma_map_pixel_chk
// port-level checks of the eye-map block, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "eye_chroma_map_pixel_macros.svh"

module eye_chroma_map_pixel_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] eye_map_value_o
);

  // a held output word keeps its value
  `ECM_ASSERT(a_out_hold, clk_i, rst_ni,
              (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(eye_map_value_o)))

  // input only stalls while an output word is held
  `ECM_ASSERT(a_in_stall_cause, clk_i, rst_ni,
              in_stall_o |-> (out_valid_o && out_stall_i))

  // no output word while reset is low
  `ECM_ASSERT_ALWAYS(a_reset_empty, clk_i, (!rst_ni) |-> (!out_valid_o))

endmodule

bind eye_chroma_map_pixel eye_chroma_map_pixel_chk u_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .eye_map_value_o(eye_map_value_o)
);

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the chroma eye-map pixel pipeline
// ----------------------------------------------------------------------------
// Pixels go in as cr/cb words and each one is scored by an in-bench
// calculation of the eye-map value. That value waits in a queue until the
// block hands back its next word. The sender runs in bursts with random gaps.
// The receiver stalls from a rotating random pattern and at times holds off
// for a long run of cycles. That fills the pipe and pushes the stall back to
// the input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned DrainSlack = 16;     // a bit more than the pipe depth
  localparam int unsigned FullScale  = 255;

  typedef struct {
    logic [7:0] cr;
    logic [7:0] cb;
    logic [7:0] eye;
  } pixel_score_t;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b1;
  logic       in_valid_i  = 1'b0;
  logic       in_stall_o;
  logic [7:0] cr_byte_i   = 8'd0;
  logic [7:0] cb_byte_i   = 8'd0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [7:0] eye_map_value_o;

  pixel_score_t score_q[$];
  pixel_score_t oldest_score;
  int unsigned  cycle_count  = 0;
  int unsigned  error_count  = 0;
  int unsigned  burst_left   = 0;
  int unsigned  hold_request = 0;
  int unsigned  hold_left    = 0;
  int unsigned  pattern_age  = 0;
  logic [15:0]  stall_pattern = 16'h0000;
  bit           sender_gaps  = 1'b0;
  bit           stall_on     = 1'b0;

  eye_chroma_map_pixel DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .cr_byte_i      (cr_byte_i),
    .cb_byte_i      (cb_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .eye_map_value_o(eye_map_value_o)
  );

  // clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // eye-map value of one pixel: squared blue, inverted red and ratio terms
  function automatic logic [7:0] eye_map_of(input logic [7:0] cr, input logic [7:0] cb);
    int unsigned red;
    int unsigned blue;
    int unsigned inv_red;
    int unsigned ratio;
    int unsigned total;
    red     = cr;
    blue    = cb;
    inv_red = FullScale - red;
    // zero red leaves the ratio at full scale
    if (red == 0) begin
      ratio = FullScale;
    end else begin
      ratio = (blue * 512) / red;
    end
    if (ratio > FullScale) begin
      ratio = FullScale;
    end
    total = ((blue * blue) / FullScale + (inv_red * inv_red) / FullScale + ratio) / 3;
    if (total > FullScale) begin
      total = FullScale;
    end
    return total[7:0];
  endfunction

  task automatic report_error(input string what);
    $display("eye-map error at cycle %0d: %s", cycle_count, what);
    error_count++;
  endtask

  // offer one pixel word and wait until it is taken
  task automatic send_pixel(input logic [7:0] cr, input logic [7:0] cb);
    int unsigned  gap;
    pixel_score_t scored;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = sender_gaps ? $urandom_range(0, 7) : 0;
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    cr_byte_i  <= cr;
    cb_byte_i  <= cb;
    do @(posedge clk_i); while (in_stall_o);
    scored.cr  = cr;
    scored.cb  = cb;
    scored.eye = eye_map_of(cr, cb);
    score_q.insert(score_q.size(), scored);
  endtask

  // stop offering and wait until every scored pixel has come back
  task automatic wait_for_drain();
    in_valid_i <= 1'b0;
    while (score_q.size() != 0) @(posedge clk_i);
  endtask

  // field value leaning towards the ends of the byte range
  function automatic logic [7:0] pick_byte();
    logic [7:0] edges[4] = '{8'd0, 8'd1, 8'd254, 8'd255};
    if ($urandom_range(0, 7) == 0) begin
      return edges[$urandom_range(0, 3)];
    end
    return 8'($urandom_range(0, 255));
  endfunction

  // receiver stall: long holds first, then a rotating random pattern
  always @(posedge clk_i) begin
    if (hold_request != 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else if (!stall_on) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i   <= stall_pattern[0];
      stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
      pattern_age++;
      if (pattern_age == 48) begin
        pattern_age = 0;
        case ($urandom_range(0, 3))
          0: stall_pattern = 16'h0000;
          1: stall_pattern = 16'($urandom & $urandom);
          2: stall_pattern = 16'($urandom);
          default: stall_pattern = 16'($urandom | $urandom);
        endcase
      end
    end
  end

  // compare each returned word with the oldest scored pixel
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (score_q.size() == 0) begin
        report_error($sformatf("unexpected word %0d", eye_map_value_o));
      end else begin
        oldest_score = score_q.pop_front();
        if (eye_map_value_o !== oldest_score.eye) begin
          report_error($sformatf("cr %0d cb %0d gave %0d, want %0d", oldest_score.cr,
                                 oldest_score.cb, eye_map_value_o, oldest_score.eye));
        end
      end
    end
  end

  // run limit
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("eye_chroma_map_pixel: mismatch");
    $finish;
  end

  // corners: zero red, saturating and small ratios, byte extremes
  task automatic test_corners();
    logic [7:0] cr_list[20] = '{8'd0, 8'd0, 8'd255, 8'd255, 8'd0, 8'd1, 8'd1, 8'd255,
                                8'd2, 8'd3, 8'd128, 8'd127, 8'hAA, 8'h55, 8'd1, 8'd254,
                                8'd64, 8'd0, 8'd200, 8'd17};
    logic [7:0] cb_list[20] = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd128, 8'd255, 8'd0, 8'd1,
                                8'd1, 8'd1, 8'd128, 8'd64, 8'h55, 8'hAA, 8'd1, 8'd254,
                                8'd32, 8'd1, 8'd99, 8'd8};
    sender_gaps = 1'b0;
    stall_on    = 1'b0;
    for (int i = 0; i < 20; i++) begin
      send_pixel(cr_list[i], cb_list[i]);
    end
  endtask

  // random pixels, idling switched on and off in phases
  task automatic test_random_pixels(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 150 == 0) begin
        sender_gaps = ((i / 150) % 3) != 0;
        stall_on    = ((i / 150) % 4) != 1;
      end
      send_pixel(pick_byte(), pick_byte());
    end
  endtask

  // receiver holds off long while the sender keeps offering
  task automatic test_backpressure();
    sender_gaps  = 1'b0;
    stall_on     = 1'b1;
    hold_request = 300;
    for (int i = 0; i < 80; i++) begin
      send_pixel(pick_byte(), pick_byte());
    end
  endtask

  // sender pauses until the pipe is empty, then starts again
  task automatic test_drain_pause();
    sender_gaps = 1'b1;
    stall_on    = 1'b1;
    for (int round = 0; round < 4; round++) begin
      for (int i = 0; i < 25; i++) begin
        send_pixel(pick_byte(), pick_byte());
      end
      wait_for_drain();
    end
  endtask

  // test sequence
  initial begin
    rst_ni <= 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_corners();
    test_random_pixels(1400);
    test_backpressure();
    test_drain_pause();
    wait_for_drain();
    repeat (DrainSlack) @(posedge clk_i);
    if (error_count == 0) begin
      $display("eye_chroma_map_pixel: match");
    end else begin
      $display("eye_chroma_map_pixel: mismatch");
    end
    $finish;
  end

endmodule
